// File: rtl/psa_pkg.sv
// ---------------------------------------------------------------------------
// psa_pkg
// Shared types and constants of the pixel sample accumulator.
// ---------------------------------------------------------------------------
package psa_pkg;

    localparam int SUM_BITS     = 32;
    localparam int SQ_BITS      = 48;
    localparam int CH_PORT_BITS = 16;
    localparam int PROD_BITS    = 2 * CH_PORT_BITS;
    localparam int COORD_BITS   = 6;
    localparam int DIM_BITS     = 7;
    localparam int NUM_CH       = 3;
    localparam int STEP_BITS    = $clog2(SUM_BITS + 1);

    localparam logic [DIM_BITS-1:0] DIM_RESET = 7'd64;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_MOMENT = 2'd2;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_WIPE,
        S_IDLE,
        S_READ,
        S_MODIFY,
        S_DIVIDE,
        S_CLEAR,
        S_DONE
    } state_t;

endpackage

// File: rtl/pixel_sample_accumulator.sv
// ---------------------------------------------------------------------------
// pixel_sample_accumulator
// Per-pixel accumulation store: RGB sums, sample counts and square sums.
//
// Sample channel: one beat per item (action, coordinates, RGB sample),
// taken when sample_valid is high and sample_stall low. Result channel: one
// beat per item, held in an output register until result_valid is seen with
// result_stall low; a stalled result holds, and the next item is still taken
// while it waits. Configuration: cfg_valid/cfg_ready write port, always ready.
// Add and read: a memory read of the pixel entry, a write-back for an add
// that does not overflow, then the 32-step mean divider. Out-of-range and
// unused actions go straight to the result. Clear: sweep of the entry memory,
// one entry per cycle over all MAX_WIDTH*MAX_HEIGHT entries.
// Reset: registers return to width 64, height 64, moments off, and the same
// sweep zeroes the memory; no item is taken until it ends. One item is in
// flight at a time.
// ---------------------------------------------------------------------------
module pixel_sample_accumulator
    import psa_pkg::*;
#(
    parameter int MAX_WIDTH    = 64,
    parameter int MAX_HEIGHT   = 64,
    parameter int COUNT_BITS   = 16,
    parameter int CHANNEL_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     sample_valid,
    output logic                     sample_stall,
    input  logic [1:0]               action,
    input  logic [COORD_BITS-1:0]    x_coord,
    input  logic [COORD_BITS-1:0]    y_coord,
    input  logic [CH_PORT_BITS-1:0]  sample_red,
    input  logic [CH_PORT_BITS-1:0]  sample_green,
    input  logic [CH_PORT_BITS-1:0]  sample_blue,

    output logic                     result_valid,
    input  logic                     result_stall,
    output logic [1:0]               status,
    output logic [CH_PORT_BITS-1:0]  mean_red,
    output logic [CH_PORT_BITS-1:0]  mean_green,
    output logic [CH_PORT_BITS-1:0]  mean_blue,
    output logic [15:0]              count_out,
    output logic [SQ_BITS-1:0]       square_sum_red,
    output logic [SQ_BITS-1:0]       square_sum_green,
    output logic [SQ_BITS-1:0]       square_sum_blue,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [1:0]               cfg_index,
    input  logic [DIM_BITS-1:0]      cfg_data
);

    localparam int DEPTH     = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CH_EFF    = (CHANNEL_BITS < CH_PORT_BITS) ? CHANNEL_BITS : CH_PORT_BITS;
    localparam logic [CH_PORT_BITS-1:0] CH_MASK =
        CH_PORT_BITS'((64'd1 << CH_EFF) - 64'd1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};
    localparam logic [ADDR_BITS-1:0]  LAST_ADDR = ADDR_BITS'(DEPTH - 1);

    typedef struct packed {
        logic [SUM_BITS-1:0]   red_sum;
        logic [SUM_BITS-1:0]   green_sum;
        logic [SUM_BITS-1:0]   blue_sum;
        logic [COUNT_BITS-1:0] count;
        logic [SQ_BITS-1:0]    red_sq;
        logic [SQ_BITS-1:0]    green_sq;
        logic [SQ_BITS-1:0]    blue_sq;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

    state_t                              state_reg, state_next;
    logic [ADDR_BITS-1:0]                clr_addr_reg, clr_addr_next;
    logic [DIM_BITS-1:0]                 width_reg;
    logic [DIM_BITS-1:0]                 height_reg;
    logic                                moment_reg;

    action_t                             act_reg, act_next;
    logic [ADDR_BITS-1:0]                addr_reg, addr_next;
    logic [NUM_CH-1:0][CH_PORT_BITS-1:0] chan_reg, chan_next;
    logic [NUM_CH-1:0][PROD_BITS-1:0]    prod_reg;
    status_t                             stat_reg, stat_next;
    logic                                report_reg, report_next;
    entry_t                              pix_reg, pix_next;

    logic                                result_valid_reg;
    status_t                             status_out_reg;
    logic [NUM_CH-1:0][CH_PORT_BITS-1:0] mean_reg;
    logic [15:0]                         count_out_reg;
    logic [NUM_CH-1:0][SQ_BITS-1:0]      sq_out_reg;

    logic                                sample_accept;
    logic                                in_range;
    logic [ADDR_BITS-1:0]                in_addr;
    logic                                load_result;

    logic                                mem_rd_en;
    logic                                mem_wr_en;
    logic [ADDR_BITS-1:0]                mem_wr_addr;
    entry_t                              mem_wr_data;
    entry_t                              rd_entry;
    entry_t                              upd_entry;

    logic                                div_start;
    logic                                div_busy;
    logic                                div_done;
    logic [NUM_CH-1:0][SUM_BITS-1:0]     div_dividend;
    logic [NUM_CH-1:0][SUM_BITS-1:0]     div_quotient;
    logic [31:0]                         cnt_wide;

    assign sample_stall  = (state_reg != S_IDLE);
    assign sample_accept = sample_valid && !sample_stall;
    assign cfg_ready     = 1'b1;

    assign in_range = ({1'b0, x_coord} < width_reg) && (32'(x_coord) < MAX_WIDTH)
                   && ({1'b0, y_coord} < height_reg) && (32'(y_coord) < MAX_HEIGHT);
    assign in_addr  = ADDR_BITS'(32'(y_coord) * MAX_WIDTH + 32'(x_coord));

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
            moment_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                CFG_MOMENT: moment_reg <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // read-modify-write of the pixel entry
    always_comb
    begin
        upd_entry           = rd_entry;
        upd_entry.red_sum   = rd_entry.red_sum   + SUM_BITS'(chan_reg[0]);
        upd_entry.green_sum = rd_entry.green_sum + SUM_BITS'(chan_reg[1]);
        upd_entry.blue_sum  = rd_entry.blue_sum  + SUM_BITS'(chan_reg[2]);
        upd_entry.count     = rd_entry.count + COUNT_BITS'(1);
        if (moment_reg)
        begin
            upd_entry.red_sq   = rd_entry.red_sq   + SQ_BITS'(prod_reg[0]);
            upd_entry.green_sq = rd_entry.green_sq + SQ_BITS'(prod_reg[1]);
            upd_entry.blue_sq  = rd_entry.blue_sq  + SQ_BITS'(prod_reg[2]);
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        act_next      = act_reg;
        addr_next     = addr_reg;
        chan_next     = chan_reg;
        stat_next     = stat_reg;
        report_next   = report_reg;
        pix_next      = pix_reg;
        mem_rd_en     = 1'b0;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = addr_reg;
        mem_wr_data   = upd_entry;
        div_start     = 1'b0;
        load_result   = 1'b0;

        case (state_reg)
            S_WIPE, S_CLEAR:
            begin
                mem_wr_en     = 1'b1;
                mem_wr_addr   = clr_addr_reg;
                mem_wr_data   = '0;
                clr_addr_next = clr_addr_reg + ADDR_BITS'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    clr_addr_next = '0;
                    stat_next     = ST_OK;
                    report_next   = 1'b0;
                    state_next    = (state_reg == S_WIPE) ? S_IDLE : S_DONE;
                end
            end
            S_IDLE:
            begin
                if (sample_accept)
                begin
                    act_next     = action_t'(action);
                    addr_next    = in_addr;
                    chan_next[0] = sample_red   & CH_MASK;
                    chan_next[1] = sample_green & CH_MASK;
                    chan_next[2] = sample_blue  & CH_MASK;
                    stat_next    = ST_OK;
                    report_next  = 1'b0;
                    case (action_t'(action))
                        ACT_CLEAR:
                        begin
                            clr_addr_next = '0;
                            state_next    = S_CLEAR;
                        end
                        ACT_ADD, ACT_READ:
                        begin
                            if (in_range)
                            begin
                                mem_rd_en  = 1'b1;
                                state_next = S_READ;
                            end
                            else
                            begin
                                stat_next  = ST_RANGE;
                                state_next = S_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                state_next = S_MODIFY;
            end
            S_MODIFY:
            begin
                report_next = 1'b1;
                stat_next   = ST_OK;
                pix_next    = rd_entry;
                if (act_reg == ACT_ADD)
                begin
                    if (rd_entry.count == CNT_MAX)
                    begin
                        stat_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        mem_wr_en = 1'b1;
                        pix_next  = upd_entry;
                    end
                end
                div_start  = 1'b1;
                state_next = S_DIVIDE;
            end
            S_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    load_result = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_WIPE;
            clr_addr_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            if (load_result)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        addr_reg   <= addr_next;
        chan_reg   <= chan_next;
        stat_reg   <= stat_next;
        report_reg <= report_next;
        pix_reg    <= pix_next;
        for (int i = 0; i < NUM_CH; i++)
        begin
            prod_reg[i] <= chan_reg[i] * chan_reg[i];
        end
    end

    assign cnt_wide = 32'(pix_reg.count);

    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            status_out_reg <= stat_reg;
            for (int i = 0; i < NUM_CH; i++)
            begin
                mean_reg[i] <= (report_reg && pix_reg.count != '0)
                             ? div_quotient[i][CH_PORT_BITS-1:0] : '0;
            end
            count_out_reg <= report_reg ? cnt_wide[15:0] : '0;
            sq_out_reg[0] <= (report_reg && moment_reg) ? pix_reg.red_sq   : '0;
            sq_out_reg[1] <= (report_reg && moment_reg) ? pix_reg.green_sq : '0;
            sq_out_reg[2] <= (report_reg && moment_reg) ? pix_reg.blue_sq  : '0;
        end
    end

    assign div_dividend[0] = pix_next.red_sum;
    assign div_dividend[1] = pix_next.green_sum;
    assign div_dividend[2] = pix_next.blue_sum;

    psa_store #(
        .DEPTH     (DEPTH),
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (ENTRY_BITS)
    ) u_store (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (in_addr),
        .rd_data (rd_entry),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    psa_divider #(
        .DIVISOR_BITS (COUNT_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (pix_next.count),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign result_valid     = result_valid_reg;
    assign status           = status_out_reg;
    assign mean_red         = mean_reg[0];
    assign mean_green       = mean_reg[1];
    assign mean_blue        = mean_reg[2];
    assign count_out        = count_out_reg;
    assign square_sum_red   = sq_out_reg[0];
    assign square_sum_green = sq_out_reg[1];
    assign square_sum_blue  = sq_out_reg[2];

`ifndef ASSERT_OFF
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !mem_wr_en)
        else $error("memory written while idle");

    a_hold_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && result_valid_reg && result_stall) |=> (state_reg == S_DONE))
        else $error("result left done while output register full");

    a_clear_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == S_CLEAR) |-> (clr_addr_reg == '0))
        else $error("clear sweep not starting at entry zero");

    a_divide_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVIDE) |-> (div_busy || div_done))
        else $error("waiting on an idle divider");
`endif

endmodule

// File: rtl/psa_store.sv
// ---------------------------------------------------------------------------
// psa_store
// Pixel entry memory: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module psa_store #(
    parameter int DEPTH     = 4096,
    parameter int ADDR_BITS = 12,
    parameter int DATA_BITS = 256
) (
    input  logic                 clk,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/psa_divider.sv
// ---------------------------------------------------------------------------
// psa_divider
// Three-lane restoring divider, one quotient bit per cycle, shared divisor.
// ---------------------------------------------------------------------------
module psa_divider
    import psa_pkg::*;
#(
    parameter int DIVISOR_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [NUM_CH-1:0][SUM_BITS-1:0]  dividend,
    input  logic [DIVISOR_BITS-1:0]          divisor,
    output logic                             busy,
    output logic                             done,
    output logic [NUM_CH-1:0][SUM_BITS-1:0]  quotient
);

    logic                                   busy_reg;
    logic                                   done_reg;
    logic [STEP_BITS-1:0]                   step_reg;
    logic [DIVISOR_BITS-1:0]                div_reg;
    logic [NUM_CH-1:0][DIVISOR_BITS-1:0]    rem_reg;
    logic [NUM_CH-1:0][DIVISOR_BITS-1:0]    rem_next;
    logic [NUM_CH-1:0][SUM_BITS-1:0]        quo_reg;
    logic [NUM_CH-1:0][SUM_BITS-1:0]        quo_next;
    logic [NUM_CH-1:0][DIVISOR_BITS:0]      trial;
    logic [NUM_CH-1:0][DIVISOR_BITS:0]      diff;
    logic [NUM_CH-1:0]                      ge;

    always_comb
    begin
        for (int i = 0; i < NUM_CH; i++)
        begin
            trial[i]    = {rem_reg[i], quo_reg[i][SUM_BITS-1]};
            diff[i]     = trial[i] - {1'b0, div_reg};
            ge[i]       = (trial[i] >= {1'b0, div_reg});
            rem_next[i] = ge[i] ? diff[i][DIVISOR_BITS-1:0] : trial[i][DIVISOR_BITS-1:0];
            quo_next[i] = {quo_reg[i][SUM_BITS-2:0], ge[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == STEP_BITS'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_BITS'(SUM_BITS);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - STEP_BITS'(1);
                if (step_reg == STEP_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && div_reg != '0) |-> (rem_reg[0] < div_reg))
        else $error("partial remainder not below divisor");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(busy_reg) && !busy_reg))
        else $error("done without a finished division");
`endif

endmodule
